// ----- sv/imm_pkg.sv -----
package imm_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DIM_W   = 4;
	localparam int DATA_W  = 32;
	localparam int REG_W   = 2;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [REG_W-1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  row_index;
		logic [IDX_W-1:0]  col_index;
		logic signed [DATA_W-1:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product_value;
		logic [IDX_W-1:0]  product_row;
		logic [IDX_W-1:0]  product_col;
		logic              last_element;
	} result_t;

	// one multiply-accumulate step issued by the controller
	typedef struct packed {
		logic              valid;
		logic              first_k;
		logic              last_k;
		logic              last_elem;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} mac_cmd_t;

	typedef struct packed {
		logic              we_a;
		logic              we_b;
		logic [ADDR_W-1:0] addr;
	} load_cmd_t;

	// largest index for a dimension register: zero acts as one, above MAX_DIM saturates
	function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] dim);
		logic [IDX_W-1:0] res;
		if (dim == '0) begin
			res = '0;
		end else if (dim > DIM_W'(MAX_DIM)) begin
			res = IDX_W'(MAX_DIM - 1);
		end else begin
			res = IDX_W'(dim - DIM_W'(1));
		end
		return res;
	endfunction

endpackage

// ----- sv/imm_ctrl.sv -----
module imm_ctrl
	import imm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output logic             busy,
	output load_cmd_t        load_cmd,
	output mac_cmd_t         mac_cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [DIM_W-1:0] rows_a_q;
	logic [DIM_W-1:0] inner_dim_q;
	logic [DIM_W-1:0] cols_b_q;
	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] r_last;
	logic [IDX_W-1:0] c_last;
	logic [IDX_W-1:0] k_last;
	logic             accept;
	logic             elem_done;

	assign r_last = last_index(rows_a_q);
	assign k_last = last_index(inner_dim_q);
	assign c_last = last_index(cols_b_q);

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(1);
			inner_dim_q <= DIM_W'(1);
			cols_b_q    <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		load_cmd.we_a = accept && (opcode == OP_WRITE_A);
		load_cmd.we_b = accept && (opcode == OP_WRITE_B);
		load_cmd.addr = {row_index, col_index};
	end

	assign elem_done = (k_q == k_last);

	always_comb begin
		mac_cmd.valid     = busy;
		mac_cmd.first_k   = (k_q == '0);
		mac_cmd.last_k    = elem_done;
		mac_cmd.last_elem = (r_q == r_last) && (c_q == c_last);
		mac_cmd.a_addr    = {r_q, k_q};
		mac_cmd.b_addr    = {k_q, c_q};
		mac_cmd.row       = r_q;
		mac_cmd.col       = c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && opcode == OP_COMPUTE) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// advance k, then column, then row; wrap to zero at the end
					if (!elem_done) begin
						k_q <= k_q + IDX_W'(1);
					end else begin
						k_q <= '0;
						if (c_q != c_last) begin
							c_q <= c_q + IDX_W'(1);
						end else begin
							c_q <= '0;
							if (r_q != r_last) begin
								r_q <= r_q + IDX_W'(1);
							end else begin
								r_q     <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (k_q <= k_last))
		else $error("inner index beyond inner dimension");
	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_cmd.valid && mac_cmd.last_k && mac_cmd.last_elem) |=> !busy)
		else $error("run did not end after final step");
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (k_q == '0 && c_q == '0 && r_q == '0))
		else $error("counters not cleared while idle");
`endif

endmodule

// ----- sv/imm_datapath.sv -----
module imm_datapath
	import imm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  load_cmd_t         load_cmd,
	input  logic [DATA_W-1:0] load_data,
	input  mac_cmd_t          mac_cmd,
	output result_t           result,
	output logic              result_valid
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];

	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	mac_cmd_t          cmd_s1;
	logic [DATA_W-1:0] prod_s2;
	mac_cmd_t          cmd_s2;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] acc_next;
	logic              valid_s1;
	logic              valid_s2;
	result_t           result_q;
	logic              result_valid_q;

	always_ff @(posedge clk) begin
		if (load_cmd.we_a) begin
			mem_a[load_cmd.addr] <= load_data;
		end
		if (load_cmd.we_b) begin
			mem_b[load_cmd.addr] <= load_data;
		end
		a_s1 <= mem_a[mac_cmd.a_addr];
		b_s1 <= mem_b[mac_cmd.b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= mac_cmd.valid;
			valid_s2       <= valid_s1;
			result_valid_q <= valid_s2 && cmd_s2.last_k;
		end
	end

	// low 32 bits of the product are the same for signed and unsigned operands
	always_ff @(posedge clk) begin
		cmd_s1  <= mac_cmd;
		cmd_s2  <= cmd_s1;
		prod_s2 <= a_s1 * b_s1;
	end

	assign acc_next = cmd_s2.first_k ? prod_s2 : acc_q + prod_s2;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= acc_next;
		end
		if (valid_s2 && cmd_s2.last_k) begin
			result_q.product_value <= acc_next;
			result_q.product_row   <= cmd_s2.row;
			result_q.product_col   <= cmd_s2.col;
			result_q.last_element  <= cmd_s2.last_elem;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ----- sv/integer_matrix_multiply_core.sv -----
// Integer matrix multiply core, C = A * B, with A and B held in on-chip stores.
// Input channel: present item and raise start; a transaction is taken on an edge
// where start is high and busy is low. Opcode write A / write B stores
// element_value at (row_index, col_index) and gives no result.
// Opcode compute streams every element of C in row-major order on result,
// each marked by result_valid for exactly one cycle; last_element flags the
// final one. Opcode 3 is dropped.
// Configuration: cfg_we, cfg_index and cfg_data write rows_a, inner_dim and
// cols_b (index 0, 1, 2); zero acts as one, above eight saturates at eight.
// Timing: one multiply-accumulate per cycle from a shared multiplier while a
// compute holds busy; each element passes the memory read, multiply and
// accumulate registers after its last step is issued. A new transaction may
// be taken as soon as busy drops.
// Reset clears control and sets all dimensions to one; store contents stay
// undefined until written. The receiver cannot stall: results are not held.
module integer_matrix_multiply_core
	import imm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_item_t         item,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output result_t          result,
	output logic             result_valid
);

	load_cmd_t load_cmd;
	mac_cmd_t  mac_cmd;

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (item.opcode),
		.row_index (item.row_index),
		.col_index (item.col_index),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.load_cmd  (load_cmd),
		.mac_cmd   (mac_cmd)
	);

	imm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_cmd     (load_cmd),
		.load_data    (item.element_value),
		.mac_cmd      (mac_cmd),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
